// ===== sv/ttoi_pkg.sv =====
package ttoi_pkg;

  // parse phases
  localparam logic [2:0] PH_WS     = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_ZEROX  = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_NOCONV = 2'd2;

  localparam logic [5:0]  RADIX_RESET = 6'd10;
  localparam logic [5:0]  BASE_AUTO   = 6'd0;
  localparam logic [5:0]  BASE_OCT    = 6'd8;
  localparam logic [5:0]  BASE_DEC    = 6'd10;
  localparam logic [5:0]  BASE_HEX    = 6'd16;
  localparam logic [5:0]  BASE_MIN    = 6'd2;
  localparam logic [5:0]  BASE_MAX    = 6'd36;
  localparam logic [5:0]  NO_DIGIT    = 6'd63;
  localparam logic [63:0] POS_LIMIT   = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG_LIMIT   = 64'h8000_0000_0000_0000;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef struct packed {
    logic [2:0]  phase;
    logic        neg;
    logic        ovf;
    logic        seen;
    logic [63:0] acc;   // magnitude
    logic [5:0]  base;
  } ttoi_state_t;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
  } ttoi_result_t;

  localparam ttoi_state_t STATE_CLEAR = '{
    phase: PH_WS, neg: 1'b0, ovf: 1'b0, seen: 1'b0, acc: 64'd0, base: 6'd0
  };

  function automatic logic [5:0] digit_of(logic [7:0] ch);
    logic [7:0] d;
    d = 8'd0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      d = ch - CH_ZERO;
    end else if (ch >= CH_UA && ch <= CH_UZ) begin
      d = ch - CH_UA + 8'd10;
    end else if (ch >= CH_LA && ch <= CH_LZ) begin
      d = ch - CH_LA + 8'd10;
    end else begin
      d = {2'b00, NO_DIGIT};
    end
    return d[5:0];
  endfunction

endpackage

// ===== sv/text_to_int64_parser_core.sv =====
// channel | dir | handshake              | payload
// in      | in  | in_tvalid / in_tready   | in_tdata[7:0] char_code
// out     | out | out_tvalid / out_tready | out_tdata[63:0] value, [65:64] status
// cfg     | in  | cfg_valid / cfg_ready   | cfg_data[5:0] radix
//
// One beat per clock sustained on the input: each char goes input register ->
// parse step (one 64x6 multiply-add and a limit compare) -> state/result regs.
// A NUL beat in the input register emits its result into the result register;
// only a NUL waiting on a full, stalled output register holds the input side.
// rst_n is synchronous, active low; radix returns to 10, parse state clears.
module text_to_int64_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [63:0] value, [65:64] status, [71:66] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data    // [5:0] radix
);
  import ttoi_pkg::*;

  // input register
  logic        in_valid_r;
  logic [7:0]  in_char_r;
  // parse state and radix
  ttoi_state_t state_r;
  ttoi_state_t state_nxt;
  logic [5:0]  radix_r;
  // result register
  logic         out_valid_r;
  ttoi_result_t out_res_r;

  logic         emit;
  ttoi_result_t res;
  logic         proc;

  ttoi_step u_step (
    .cur   (state_r),
    .radix (radix_r),
    .ch    (in_char_r),
    .nxt   (state_nxt),
    .emit  (emit),
    .res   (res)
  );

  // a held char moves on unless it is a NUL and the output slot is still full
  assign proc      = in_valid_r && (in_char_r != CH_NUL || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.status, out_res_r.value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_CLEAR;
      radix_r     <= RADIX_RESET;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (proc) begin
        state_r <= state_nxt;
      end
      if (proc && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        radix_r <= cfg_data;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
    end
    if (proc && emit) begin
      out_res_r <= res;
    end
  end

endmodule

// ===== sv/ttoi_step.sv =====
module ttoi_step (
  input  ttoi_pkg::ttoi_state_t  cur,
  input  logic [5:0]             radix,
  input  logic [7:0]             ch,
  output ttoi_pkg::ttoi_state_t  nxt,
  output logic                   emit,
  output ttoi_pkg::ttoi_result_t res
);
  import ttoi_pkg::*;

  // one digit: acc*base+d formed exactly (70 bits) and checked against the limit
  function automatic ttoi_state_t take_digit(ttoi_state_t s, logic [7:0] c);
    ttoi_state_t n;
    logic [5:0]  d;
    logic [69:0] wide;
    logic [63:0] limit;
    n     = s;
    d     = digit_of(c);
    limit = s.neg ? NEG_LIMIT : POS_LIMIT;
    wide  = ({6'd0, s.acc} * {64'd0, s.base}) + {64'd0, d};
    if (d >= s.base) begin
      n.phase = PH_DONE;
    end else begin
      n.phase = PH_DIGITS;
      n.seen  = 1'b1;
      if (!s.ovf) begin
        if (wide > {6'd0, limit}) begin
          n.ovf = 1'b1;
        end else begin
          n.acc = wide[63:0];
        end
      end
    end
    return n;
  endfunction

  function automatic ttoi_state_t start_number(ttoi_state_t s, logic [7:0] c,
                                               logic [5:0] r);
    ttoi_state_t n;
    n = s;
    if ((r == BASE_AUTO || r == BASE_HEX) && c == CH_ZERO) begin
      n.base  = r;
      n.phase = PH_ZERO;
    end else begin
      n.base = (r == BASE_AUTO) ? BASE_DEC : r;
      if (n.base < BASE_MIN || n.base > BASE_MAX) begin
        n.phase = PH_DONE;
      end else begin
        n = take_digit(n, c);
      end
    end
    return n;
  endfunction

  // a leading '0' that did not become a hex prefix counts as digit zero
  function automatic ttoi_state_t settle_zero(ttoi_state_t s);
    ttoi_state_t n;
    n       = s;
    n.base  = (s.base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
    n.acc   = 64'd0;
    n.seen  = 1'b1;
    n.phase = PH_DIGITS;
    return n;
  endfunction

  ttoi_state_t fin;
  ttoi_state_t tmp;

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    fin  = cur;
    tmp  = cur;
    res  = '{value: 64'd0, status: ST_NOCONV};
    if (ch == CH_NUL) begin
      emit = 1'b1;
      if (cur.phase == PH_ZERO || cur.phase == PH_ZEROX) begin
        fin = settle_zero(cur);
      end
      if (fin.ovf) begin
        res.value  = fin.neg ? NEG_LIMIT : POS_LIMIT;
        res.status = ST_RANGE;
      end else if (!fin.seen) begin
        res.value  = 64'd0;
        res.status = ST_NOCONV;
      end else begin
        res.value  = fin.neg ? (64'd0 - fin.acc) : fin.acc;
        res.status = ST_OK;
      end
      nxt = STATE_CLEAR;
    end else begin
      unique case (cur.phase)
        PH_WS: begin
          if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
            nxt = cur;
          end else if (ch == CH_MINUS) begin
            nxt.neg   = 1'b1;
            nxt.phase = PH_SIGN;
          end else if (ch == CH_PLUS) begin
            nxt.phase = PH_SIGN;
          end else begin
            nxt = start_number(cur, ch, radix);
          end
        end
        PH_SIGN: begin
          nxt = start_number(cur, ch, radix);
        end
        PH_ZERO: begin
          if (ch == CH_LX || ch == CH_UX) begin
            nxt.phase = PH_ZEROX;
          end else begin
            nxt = take_digit(settle_zero(cur), ch);
          end
        end
        PH_ZEROX: begin
          if (digit_of(ch) < BASE_HEX) begin
            tmp.base = BASE_HEX;
            tmp.acc  = 64'd0;
            nxt      = take_digit(tmp, ch);
          end else begin
            nxt       = settle_zero(cur);
            nxt.phase = PH_DONE;
          end
        end
        PH_DIGITS: begin
          nxt = take_digit(cur, ch);
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule

// ===== bench/tb_text_to_int64_parser_core.sv =====
`timescale 1ns / 100ps

module tb_text_to_int64_parser_core;
  import ttoi_pkg::*;

  localparam int ITEM_TARGET    = 1800;  // chars in the random part
  localparam int PHASE_CHARS    = 150;   // chars per radix setting
  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any beat
  localparam int REPORT_LIMIT   = 10;

  // Tracks the strtoll-style parse of the accepted chars and holds the
  // conversions still owed by the block.
  class ttoi_checker;
    logic [5:0]   radix;
    logic [2:0]   phase;
    logic         neg;
    logic         ovf;
    logic         seen;
    logic [63:0]  acc;    // magnitude
    logic [5:0]   base;
    ttoi_result_t due[$];
    int           errors;

    function new();
      radix  = RADIX_RESET;
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_WS;
      neg   = 1'b0;
      ovf   = 1'b0;
      seen  = 1'b0;
      acc   = 64'd0;
      base  = 6'd0;
    endfunction

    function void load_radix(logic [5:0] r);
      radix = r;
    endfunction

    // 0..35, or 99 for anything that is never a digit
    function int char_value(logic [7:0] ch);
      if (ch >= CH_ZERO && ch <= CH_NINE) return int'(ch - CH_ZERO);
      if (ch >= CH_UA && ch <= CH_UZ) return int'(ch - CH_UA) + 10;
      if (ch >= CH_LA && ch <= CH_LZ) return int'(ch - CH_LA) + 10;
      return 99;
    endfunction

    function void add_digit(logic [7:0] ch);
      int          d;
      logic [63:0] limit;
      logic [70:0] wide;
      d = char_value(ch);
      if (d >= int'(base)) begin
        phase = PH_DONE;
        return;
      end
      phase = PH_DIGITS;
      seen  = 1'b1;
      if (ovf) return;
      limit = neg ? NEG_LIMIT : POS_LIMIT;
      // exact product: 64-bit magnitude times a 6-bit base plus a digit
      wide = 71'(acc) * 71'(base) + 71'(d);
      if (wide > 71'(limit)) ovf = 1'b1;
      else acc = wide[63:0];
    endfunction

    // first char after whitespace and sign: radix is sampled here
    function void open_number(logic [7:0] ch);
      if ((radix == BASE_AUTO || radix == BASE_HEX) && ch == CH_ZERO) begin
        base  = radix;
        phase = PH_ZERO;
        return;
      end
      base = (radix == BASE_AUTO) ? BASE_DEC : radix;
      if (base < BASE_MIN || base > BASE_MAX) begin
        phase = PH_DONE;
        return;
      end
      add_digit(ch);
    endfunction

    // a leading '0' with no usable hex prefix counts as the digit 0
    function void zero_is_digit();
      base  = (base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
      acc   = 64'd0;
      seen  = 1'b1;
      phase = PH_DIGITS;
    endfunction

    function void take_char(logic [7:0] ch);
      ttoi_result_t res;
      if (ch == CH_NUL) begin
        if (phase == PH_ZERO || phase == PH_ZEROX) zero_is_digit();
        if (ovf) begin
          res.value  = neg ? NEG_LIMIT : POS_LIMIT;
          res.status = ST_RANGE;
        end else if (!seen) begin
          res.value  = 64'd0;
          res.status = ST_NOCONV;
        end else begin
          res.value  = neg ? (64'd0 - acc) : acc;
          res.status = ST_OK;
        end
        due.push_back(res);
        clear();
        return;
      end
      case (phase)
        PH_WS: begin
          if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) return;
          if (ch == CH_MINUS) begin
            neg   = 1'b1;
            phase = PH_SIGN;
          end else if (ch == CH_PLUS) begin
            phase = PH_SIGN;
          end else begin
            open_number(ch);
          end
        end
        PH_SIGN: open_number(ch);
        PH_ZERO: begin
          if (ch == CH_LX || ch == CH_UX) begin
            phase = PH_ZEROX;
          end else begin
            zero_is_digit();
            add_digit(ch);
          end
        end
        PH_ZEROX: begin
          if (char_value(ch) < 16) begin
            base = BASE_HEX;
            acc  = 64'd0;
            add_digit(ch);
          end else begin
            // "0x" with no hex digit after it: just the 0, stopped at the x
            zero_is_digit();
            phase = PH_DONE;
          end
        end
        PH_DIGITS: add_digit(ch);
        default: ;  // stopped: ignore until NUL
      endcase
    endfunction

    function void check_conversion(logic [63:0] value, logic [1:0] status);
      ttoi_result_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result value %h status %0d", $time, value, status);
        return;
      end
      want = due.pop_front();
      if (want.value !== value || want.status !== status) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: mismatch, expected value %h status %0d, got value %h status %0d",
                   $time, want.value, want.status, value, status);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;   // [7:0] char_code
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;           // [63:0] value, [65:64] status, [71:66] zero
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data   = 6'd0;   // [5:0] radix

  ttoi_checker sb;
  int          chars_sent = 0;
  int          in_rush    = 0;      // beats left in a no-gap stretch

  text_to_int64_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // beat monitor: everything sampled at the edge, before this edge's updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.load_radix(cfg_data);
      if (in_tvalid && in_tready) sb.take_char(in_tdata);
      if (out_tvalid && out_tready) sb.check_conversion(out_tdata[63:0], out_tdata[65:64]);
    end
  end

  // result side: random ready stalls, with bursts of none
  initial begin : result_sink
    int stall;
    int rush;
    rush = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rush > 0) rush--;
      else if ($urandom_range(0, 15) == 0) rush = $urandom_range(10, 60);
      stall = (rush > 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("tb_text_to_int64_parser_core failed");
    $finish;
  end

  // one char beat; valid stays high afterwards unless the next call idles
  task automatic send_char(input logic [7:0] ch);
    int gap;
    if (in_rush > 0) in_rush--;
    else if ($urandom_range(0, 15) == 0) in_rush = $urandom_range(10, 60);
    gap = (in_rush > 0) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    do @(posedge clk); while (!in_tready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CH_NUL);
  endtask

  // all owed results back, then the input and result registers allowed to empty
  task automatic drain();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radix(input logic [5:0] r);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return CH_ZERO + 8'(d);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10);
  endfunction

  // mostly well-formed numbers with random content and edge magnitudes;
  // the rest is byte noise and broken prefixes or signs
  task automatic send_random_number(input logic [5:0] r);
    logic [7:0]  txt[$];
    logic [7:0]  digs[$];
    logic [63:0] mag;
    int          b;
    int          flaw;
    txt = {};
    digs = {};
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(0, 8)) txt.push_back(8'($urandom_range(1, 255)));
    end else begin
      flaw = $urandom_range(0, 19);
      repeat ($urandom_range(0, 2))
        txt.push_back($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
      case ($urandom_range(0, 3))
        0: txt.push_back(CH_MINUS);
        1: txt.push_back(CH_PLUS);
        default: ;
      endcase
      if (flaw == 0) txt.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      if (flaw == 1) txt.push_back(CH_SPACE);
      if (flaw == 2) txt.push_back(8'($urandom_range(128, 255)));
      if (r == BASE_AUTO) begin
        case ($urandom_range(0, 2))
          0: b = BASE_OCT;
          1: b = BASE_DEC;
          default: b = BASE_HEX;
        endcase
      end else if (r >= BASE_MIN && r <= BASE_MAX) begin
        b = r;
      end else begin
        b = BASE_DEC;
      end
      if (flaw == 3) begin
        // prefix with no hex digit behind it
        txt.push_back(CH_ZERO);
        txt.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
      end else begin
        if (r == BASE_AUTO && b == BASE_OCT) txt.push_back(CH_ZERO);
        if (b == BASE_HEX && (r == BASE_AUTO || r == BASE_HEX) && $urandom_range(0, 1)) begin
          txt.push_back(CH_ZERO);
          txt.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
        end
        case ($urandom_range(0, 7))
          0: mag = 64'd0;
          1: mag = POS_LIMIT;
          2: mag = NEG_LIMIT;
          3: mag = '1;
          4: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
          5: mag = 64'($urandom_range(0, 1000));
          default: mag = {$urandom, $urandom};
        endcase
        do begin
          digs.push_front(digit_char(int'(mag % b)));
          mag = mag / b;
        end while (mag != 0);
        txt = {txt, digs};
        // extra digits may push past the int64 range
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 3)) txt.push_back(digit_char($urandom_range(0, b - 1)));
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(1, 255)));
    end
    txt.push_back(CH_NUL);
    foreach (txt[i]) send_char(txt[i]);
  endtask

  initial begin : stimulus
    logic [5:0] sweep[8];
    logic [5:0] r;
    int         phase_idx;
    int         phase_start;
    sb = new();
    // extreme settings first, including the ones that never convert
    sweep = '{BASE_AUTO, BASE_MIN, BASE_MAX, BASE_HEX, 6'd1, 6'd63, BASE_DEC, BASE_OCT};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset radix (decimal)
    send_text("\t+7\3779");  // tab, sign, digit, byte 255 stops, rest ignored
    send_text("-+1");        // second sign
    send_text("- 5");        // whitespace after sign
    send_text("");           // bare terminator
    write_radix(BASE_AUTO);
    send_text("0x");         // terminator right after the prefix
    send_text("0Xg");        // prefix without hex digit
    send_text("017");        // octal by leading zero
    send_text("0");
    write_radix(BASE_HEX);
    send_text("-0xF");

    phase_idx = 0;
    chars_sent = 0;
    while (chars_sent < ITEM_TARGET) begin
      if (phase_idx < 8) r = sweep[phase_idx];
      else if ($urandom_range(0, 9) < 7) r = 6'($urandom_range(0, 36));
      else r = 6'($urandom_range(0, 63));
      write_radix(r);
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS && chars_sent < ITEM_TARGET)
        send_random_number(r);
      phase_idx++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.due.size() != 0) begin
      sb.errors += sb.due.size();
      $display("%0d results never arrived", sb.due.size());
    end
    if (sb.errors == 0) begin
      $display("tb_text_to_int64_parser_core passed");
    end else begin
      $display("tb_text_to_int64_parser_core failed");
    end
    $finish;
  end

endmodule
